>>> rtl/core/ffrf_pkg.sv
// shared constants, command types and helpers for the follow filtered recent feed block
package ffrf_pkg;

   localparam int USERS     = 16;
   localparam int LOG_DEPTH = 256;
   localparam int FEED_LEN  = 10;

   localparam int KIND_W = 2;
   localparam int USER_W = 4;
   localparam int ID_W   = 16;

   localparam int IDX_W   = $clog2(LOG_DEPTH);
   localparam int CNT_W   = $clog2(LOG_DEPTH + 1);
   localparam int FOUND_W = $clog2(FEED_LEN + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_POST     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FEED     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FOLLOW   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNFOLLOW = 2'd3;

   typedef enum logic [1:0] {
      OP_POST,
      OP_FEED,
      OP_FOLLOW,
      OP_UNFOLLOW
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              valid_user;
      logic [USER_W-1:0] user;
      logic [USER_W-1:0] other_user;
      logic [ID_W-1:0]   post_id;
   } cmd_type;

   typedef struct packed {
      logic [USER_W-1:0] poster;
      logic [ID_W-1:0]   id;
   } entry_type;

   function automatic logic user_in_range(input logic [USER_W-1:0] u);
      return {{(8 - USER_W){1'b0}}, u} < 8'(USERS);
   endfunction

endpackage

>>> rtl/core/follow_filtered_recent_feed.sv
// top level of the follow filtered recent feed block
// Each request beat is one command: post, feed query, follow or unfollow. Commands enter a
// four-deep queue and are executed one at a time. Post, follow and unfollow are executed by
// the back end in its idle state and give no response. A feed query walks the 256-entry
// post log from newest to oldest, one entry per cycle through the log memory's read port
// while the response side does not stall, and returns up to 10 post ids (last set on the
// final one), or one beat with found clear when nothing matches. The follow matrix is
// cleared by reset at once.
module follow_filtered_recent_feed (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ffrf_pkg::KIND_W-1:0]   req_kind,
   input  logic [ffrf_pkg::USER_W-1:0]   req_user,
   input  logic [ffrf_pkg::USER_W-1:0]   req_other_user,
   input  logic [ffrf_pkg::ID_W-1:0]     req_post_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffrf_pkg::ID_W-1:0]     rsp_feed_post_id,
   output logic                          rsp_found,
   output logic                          rsp_last
);

   ffrf_pkg::cmd_type push_cmd;
   ffrf_pkg::cmd_type queue_cmd;
   logic              push;
   logic              queue_full;
   logic              queue_valid;
   logic              pop;

   ffrf_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_user       (req_user),
      .req_other_user (req_other_user),
      .req_post_id    (req_post_id),
      .queue_full     (queue_full),
      .push           (push),
      .cmd            (push_cmd)
   );

   ffrf_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd)
   );

   ffrf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (queue_valid),
      .cmd              (queue_cmd),
      .cmd_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_feed_post_id (rsp_feed_post_id),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last)
   );

   a_empty_feed_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && (rsp_feed_post_id == '0))
      else $error("empty feed beat without last or with nonzero id");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_ready_when_queue_free: assert property (@(posedge clock) disable iff (reset)
      !queue_full |-> req_ready)
      else $error("request stalled while command queue has room");

   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_valid)
      else $error("command popped from empty queue");

endmodule

>>> rtl/core/ffrf_front.sv
// front end: accepts request beats and classifies them into queued commands
module ffrf_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ffrf_pkg::KIND_W-1:0]   req_kind,
   input  logic [ffrf_pkg::USER_W-1:0]   req_user,
   input  logic [ffrf_pkg::USER_W-1:0]   req_other_user,
   input  logic [ffrf_pkg::ID_W-1:0]     req_post_id,
   input  logic                          queue_full,
   output logic                          push,
   output ffrf_pkg::cmd_type             cmd
);

   logic user_ok;
   logic other_ok;

   assign user_ok   = ffrf_pkg::user_in_range(req_user);
   assign other_ok  = ffrf_pkg::user_in_range(req_other_user);
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      cmd.user       = req_user;
      cmd.other_user = req_other_user;
      cmd.post_id    = req_post_id;
      unique case (req_kind)
         ffrf_pkg::KIND_POST: begin
            cmd.op         = ffrf_pkg::OP_POST;
            cmd.valid_user = user_ok;
         end
         ffrf_pkg::KIND_FEED: begin
            cmd.op         = ffrf_pkg::OP_FEED;
            cmd.valid_user = user_ok;
         end
         ffrf_pkg::KIND_FOLLOW: begin
            cmd.op         = ffrf_pkg::OP_FOLLOW;
            cmd.valid_user = user_ok && other_ok;
         end
         ffrf_pkg::KIND_UNFOLLOW: begin
            cmd.op         = ffrf_pkg::OP_UNFOLLOW;
            cmd.valid_user = user_ok && other_ok;
         end
      endcase
   end

endmodule

>>> rtl/core/ffrf_cmd_queue.sv
// short command queue between the front end and the execution back end
module ffrf_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ffrf_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              cmd_valid,
   output ffrf_pkg::cmd_type cmd
);

   ffrf_pkg::cmd_type                 slot_ff [ffrf_pkg::QUEUE_DEPTH];
   logic [ffrf_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ffrf_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ffrf_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full      = count_ff == ffrf_pkg::Q_CNT_W'(ffrf_pkg::QUEUE_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ffrf_pkg::Q_PTR_W'(ffrf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ffrf_pkg::Q_PTR_W'(ffrf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/ffrf_back.sv
// back end: follow matrix, post log ring, feed scan and result register
module ffrf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   input  ffrf_pkg::cmd_type           cmd,
   output logic                        cmd_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ffrf_pkg::ID_W-1:0]   rsp_feed_post_id,
   output logic                        rsp_found,
   output logic                        rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                                           state_ff, state_in;
   logic [ffrf_pkg::USERS-1:0][ffrf_pkg::USERS-1:0]     follow_ff, follow_in;
   logic [ffrf_pkg::IDX_W-1:0]              head_ff, head_in;
   logic [ffrf_pkg::CNT_W-1:0]              count_ff, count_in;
   logic [ffrf_pkg::USERS-1:0]              mask_ff, mask_in;
   logic [ffrf_pkg::IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic [ffrf_pkg::CNT_W-1:0]              left_ff, left_in;
   logic                                    pipe_ff, pipe_in;
   logic [ffrf_pkg::FOUND_W-1:0]            found_cnt_ff, found_cnt_in;
   logic                                    hold_valid_ff, hold_valid_in;
   logic [ffrf_pkg::ID_W-1:0]               hold_id_ff, hold_id_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [ffrf_pkg::ID_W-1:0]               rsp_id_ff;
   logic                                    rsp_found_ff;
   logic                                    rsp_last_ff;

   ffrf_pkg::entry_type                     log_mem [ffrf_pkg::LOG_DEPTH];
   ffrf_pkg::entry_type                     rd_data_ff;

   logic                                    mem_we;
   logic                                    rd_en;
   logic [ffrf_pkg::IDX_W-1:0]              prev_idx;
   logic                                    out_free;
   logic                                    out_we;
   logic [ffrf_pkg::ID_W-1:0]               out_id;
   logic                                    out_found;
   logic                                    out_last;
   logic                                    hit;
   logic                                    scan_end;
   logic                                    stall;
   logic [ffrf_pkg::FOUND_W-1:0]            found_next;
   logic                                    issue;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
   assign prev_idx = (rd_idx_ff == '0) ? ffrf_pkg::IDX_W'(ffrf_pkg::LOG_DEPTH - 1) :
                     rd_idx_ff - 1'b1;

   assign hit = pipe_ff && ffrf_pkg::user_in_range(rd_data_ff.poster) &&
                mask_ff[rd_data_ff.poster] &&
                (found_cnt_ff != ffrf_pkg::FOUND_W'(ffrf_pkg::FEED_LEN));
   assign scan_end = (found_cnt_ff == ffrf_pkg::FOUND_W'(ffrf_pkg::FEED_LEN)) ||
                     ((left_ff == '0) && !pipe_ff);
   assign stall      = hit && hold_valid_ff && !out_free;
   assign found_next = hit ? found_cnt_ff + 1'b1 : found_cnt_ff;
   assign issue      = (state_ff == ST_SCAN) && !scan_end && !stall && (left_ff != '0) &&
                       (found_next != ffrf_pkg::FOUND_W'(ffrf_pkg::FEED_LEN));

   always_comb begin
      state_in      = state_ff;
      follow_in     = follow_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      mask_in       = mask_ff;
      rd_idx_in     = rd_idx_ff;
      left_in       = left_ff;
      pipe_in       = pipe_ff;
      found_cnt_in  = found_cnt_ff;
      hold_valid_in = hold_valid_ff;
      hold_id_in    = hold_id_ff;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      out_we        = 1'b0;
      out_id        = hold_id_ff;
      out_found     = 1'b1;
      out_last      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  ffrf_pkg::OP_POST: begin
                     if (cmd.valid_user) begin
                        mem_we  = 1'b1;
                        head_in = (head_ff == ffrf_pkg::IDX_W'(ffrf_pkg::LOG_DEPTH - 1)) ?
                                  '0 : head_ff + 1'b1;
                        if (count_ff != ffrf_pkg::CNT_W'(ffrf_pkg::LOG_DEPTH)) begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  ffrf_pkg::OP_FOLLOW: begin
                     if (cmd.valid_user) begin
                        follow_in[cmd.user][cmd.other_user] = 1'b1;
                     end
                  end
                  ffrf_pkg::OP_UNFOLLOW: begin
                     if (cmd.valid_user) begin
                        follow_in[cmd.user][cmd.other_user] = 1'b0;
                     end
                  end
                  ffrf_pkg::OP_FEED: begin
                     mask_in       = follow_ff[cmd.user] |
                                     ({{(ffrf_pkg::USERS - 1){1'b0}}, 1'b1} << cmd.user);
                     left_in       = cmd.valid_user ? count_ff : '0;
                     rd_idx_in     = head_ff;
                     found_cnt_in  = '0;
                     hold_valid_in = 1'b0;
                     pipe_in       = 1'b0;
                     state_in      = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               pipe_in  = 1'b0;
               state_in = ST_DONE;
            end else if (!stall) begin
               if (hit) begin
                  found_cnt_in  = found_next;
                  hold_valid_in = 1'b1;
                  hold_id_in    = rd_data_ff.id;
                  if (hold_valid_ff) begin
                     out_we = 1'b1;
                  end
               end
               pipe_in = issue;
               if (issue) begin
                  rd_en     = 1'b1;
                  rd_idx_in = prev_idx;
                  left_in   = left_ff - 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_we        = 1'b1;
               out_id        = hold_valid_ff ? hold_id_ff : '0;
               out_found     = hold_valid_ff;
               out_last      = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_we) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         follow_ff     <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         left_ff       <= '0;
         pipe_ff       <= 1'b0;
         found_cnt_ff  <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         follow_ff     <= follow_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         left_ff       <= left_in;
         pipe_ff       <= pipe_in;
         found_cnt_ff  <= found_cnt_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff    <= mask_in;
      rd_idx_ff  <= rd_idx_in;
      hold_id_ff <= hold_id_in;
      if (out_we) begin
         rsp_id_ff    <= out_id;
         rsp_found_ff <= out_found;
         rsp_last_ff  <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         log_mem[head_ff] <= '{poster: cmd.user, id: cmd.post_id};
      end
      if (rd_en) begin
         rd_data_ff <= log_mem[prev_idx];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_feed_post_id = rsp_id_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> verif/follow_filtered_recent_feed_tb.sv
// self-checking testbench for the follow filtered recent feed block
`timescale 1ns / 100ps

module follow_filtered_recent_feed_tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 145;
   localparam int DIR_ROWS     = 24;
   localparam int MAX_LINES    = 200;

   typedef struct packed {
      logic [ffrf_pkg::ID_W-1:0] post_id;
      logic                      found;
      logic                      last;
   } feed_beat_type;

   typedef struct packed {
      logic [ffrf_pkg::KIND_W-1:0] kind;
      logic [ffrf_pkg::USER_W-1:0] user;
      logic [ffrf_pkg::USER_W-1:0] other;
      logic [ffrf_pkg::ID_W-1:0]   pid;
      logic                        typed;
      feed_beat_type               exp;
   } dir_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [ffrf_pkg::KIND_W-1:0] req_kind;
   logic [ffrf_pkg::USER_W-1:0] req_user;
   logic [ffrf_pkg::USER_W-1:0] req_other_user;
   logic [ffrf_pkg::ID_W-1:0]   req_post_id;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [ffrf_pkg::ID_W-1:0]   rsp_feed_post_id;
   logic                        rsp_found;
   logic                        rsp_last;

   // predictor state
   logic [ffrf_pkg::USERS-1:0]  follow_rows [ffrf_pkg::USERS];
   logic [ffrf_pkg::USER_W-1:0] log_poster  [ffrf_pkg::LOG_DEPTH];
   logic [ffrf_pkg::ID_W-1:0]   log_post_id [ffrf_pkg::LOG_DEPTH];
   int                          log_wr_ptr;
   int                          log_fill;

   feed_beat_type feed_expect_q [$];
   dir_row_type   dir_rows [DIR_ROWS];

   feed_beat_type cur_exp;
   bit            cur_typed;
   int            send_idle_pct;
   int            recv_idle_pct;
   bit            hold_req;
   int            hold_left;
   int            cycle_count;
   int            err_count;
   int            err_lines;

   follow_filtered_recent_feed DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_user         (req_user),
      .req_other_user   (req_other_user),
      .req_post_id      (req_post_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_feed_post_id (rsp_feed_post_id),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_beat(input feed_beat_type b);
      feed_expect_q = {feed_expect_q, b};
   endfunction

   task automatic apply_command(input logic [ffrf_pkg::KIND_W-1:0] kind,
                                input logic [ffrf_pkg::USER_W-1:0] user,
                                input logic [ffrf_pkg::USER_W-1:0] other,
                                input logic [ffrf_pkg::ID_W-1:0]   pid);
      logic [ffrf_pkg::USERS-1:0] mask;
      int                         idx;
      int                         n;
      int                         i;
      feed_beat_type              pend;
      if (kind == ffrf_pkg::KIND_POST) begin
         if (int'(user) < ffrf_pkg::USERS) begin
            log_poster[log_wr_ptr]  = user;
            log_post_id[log_wr_ptr] = pid;
            log_wr_ptr = (log_wr_ptr + 1 >= ffrf_pkg::LOG_DEPTH) ? 0 : log_wr_ptr + 1;
            if (log_fill < ffrf_pkg::LOG_DEPTH) log_fill++;
         end
      end else if (kind == ffrf_pkg::KIND_FOLLOW || kind == ffrf_pkg::KIND_UNFOLLOW) begin
         if (int'(user) < ffrf_pkg::USERS && int'(other) < ffrf_pkg::USERS) begin
            if (kind == ffrf_pkg::KIND_FOLLOW) follow_rows[user][other] = 1'b1;
            else follow_rows[user][other] = 1'b0;
         end
      end else begin
         n = 0;
         pend = '0;
         if (int'(user) < ffrf_pkg::USERS) begin
            mask = follow_rows[user];
            mask[user] = 1'b1;
            idx = log_wr_ptr;
            for (i = 0; i < log_fill && n < ffrf_pkg::FEED_LEN; i++) begin
               idx = (idx == 0) ? ffrf_pkg::LOG_DEPTH - 1 : idx - 1;
               if (int'(log_poster[idx]) < ffrf_pkg::USERS && mask[log_poster[idx]]) begin
                  if (n > 0) queue_beat(pend);
                  pend = '{log_post_id[idx], 1'b1, 1'b0};
                  n++;
               end
            end
         end
         if (n == 0) pend = '{'0, 1'b0, 1'b1};
         else pend.last = 1'b1;
         queue_beat(pend);
      end
   endtask

   task automatic send_cmd(input logic [ffrf_pkg::KIND_W-1:0] kind,
                           input logic [ffrf_pkg::USER_W-1:0] user,
                           input logic [ffrf_pkg::USER_W-1:0] other,
                           input logic [ffrf_pkg::ID_W-1:0]   pid,
                           input bit typed, input feed_beat_type exp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      cur_typed = typed;
      cur_exp   = exp;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_user       <= user;
      req_other_user <= other;
      req_post_id    <= pid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random;
      int                          r;
      logic [ffrf_pkg::KIND_W-1:0] kind;
      logic [ffrf_pkg::USER_W-1:0] user;
      logic [ffrf_pkg::USER_W-1:0] other;
      r = $urandom_range(99);
      if (r < 60) kind = ffrf_pkg::KIND_POST;
      else if (r < 85) kind = ffrf_pkg::KIND_FEED;
      else if (r < 95) kind = ffrf_pkg::KIND_FOLLOW;
      else kind = ffrf_pkg::KIND_UNFOLLOW;
      user  = $urandom_range(1) ? ffrf_pkg::USER_W'($urandom_range(3)) :
                                  ffrf_pkg::USER_W'($urandom_range(15));
      other = $urandom_range(1) ? ffrf_pkg::USER_W'($urandom_range(3)) :
                                  ffrf_pkg::USER_W'($urandom_range(15));
      send_cmd(kind, user, other, ffrf_pkg::ID_W'($urandom), 1'b0, '0);
   endtask

   task automatic wait_drained;
      while (feed_expect_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // response check first, then prediction of the request beat at this edge
   always @(posedge clock) begin
      feed_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (feed_expect_q.size() == 0) begin
            err_count++;
            if (err_lines < MAX_LINES) begin
               err_lines++;
               $display("%0t unexpected beat: id %h found %b last %b", $time,
                        rsp_feed_post_id, rsp_found, rsp_last);
            end
         end else begin
            want = feed_expect_q.pop_front();
            if (want.post_id !== rsp_feed_post_id || want.found !== rsp_found ||
                want.last !== rsp_last) begin
               err_count++;
               if (err_lines < MAX_LINES) begin
                  err_lines++;
                  $display("%0t mismatch: expected %h %b %b, got %h %b %b",
                           $time, want.post_id, want.found, want.last,
                           rsp_feed_post_id, rsp_found, rsp_last);
               end
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         if (cur_typed) queue_beat(cur_exp);
         else apply_command(req_kind, req_user, req_other_user, req_post_id);
      end
   end

   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      int k;
      int ph;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = ffrf_pkg::KIND_POST;
      req_user       = '0;
      req_other_user = '0;
      req_post_id    = '0;
      cur_typed      = 1'b0;
      cur_exp        = '0;
      hold_req       = 1'b0;
      cycle_count    = 0;
      err_count      = 0;
      err_lines      = 0;
      send_idle_pct  = 29;
      recv_idle_pct  = 62;
      log_wr_ptr     = 0;
      log_fill       = 0;
      for (k = 0; k < ffrf_pkg::USERS; k++) follow_rows[k] = '0;

      dir_rows = '{
         '{ffrf_pkg::KIND_FEED,     4'd0,  4'd0,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
         '{ffrf_pkg::KIND_FEED,     4'd15, 4'd15, 16'hffff, 1'b1, '{16'h0000, 1'b0, 1'b1}},
         '{ffrf_pkg::KIND_POST,     4'd15, 4'd15, 16'hffff, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd15, 4'd0,  16'h0000, 1'b1, '{16'hffff, 1'b1, 1'b1}},
         '{ffrf_pkg::KIND_FEED,     4'd0,  4'd0,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
         '{ffrf_pkg::KIND_FOLLOW,   4'd0,  4'd15, 16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FOLLOW,   4'd0,  4'd15, 16'hffff, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd0,  4'd0,  16'h0000, 1'b1, '{16'hffff, 1'b1, 1'b1}},
         '{ffrf_pkg::KIND_POST,     4'd0,  4'd0,  16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd0,  4'd15, 16'hffff, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FOLLOW,   4'd3,  4'd3,  16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd3,  4'd0,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
         '{ffrf_pkg::KIND_POST,     4'd3,  4'd0,  16'h1234, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_UNFOLLOW, 4'd3,  4'd3,  16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd3,  4'd0,  16'h0000, 1'b1, '{16'h1234, 1'b1, 1'b1}},
         '{ffrf_pkg::KIND_UNFOLLOW, 4'd5,  4'd7,  16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd5,  4'd0,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
         '{ffrf_pkg::KIND_UNFOLLOW, 4'd0,  4'd15, 16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd0,  4'd0,  16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b1}},
         '{ffrf_pkg::KIND_POST,     4'd9,  4'd6,  16'h8000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_POST,     4'd9,  4'd9,  16'h7fff, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd9,  4'd0,  16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FOLLOW,   4'd0,  4'd9,  16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
         '{ffrf_pkg::KIND_FEED,     4'd0,  4'd0,  16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < DIR_ROWS; k++) begin
         send_cmd(dir_rows[k].kind, dir_rows[k].user, dir_rows[k].other, dir_rows[k].pid,
                  dir_rows[k].typed, dir_rows[k].exp);
      end

      for (ph = 0; ph < 3; ph++) begin
         req_valid <= 1'b0;
         wait_drained();
         @(negedge clock);
         case (ph)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_req      = 1'b1;
            end
         endcase
         for (k = 0; k < PHASE_ITEMS; k++) send_random();
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
